// File: src/mavlink_v2_frame_parser_top_defines.svh
// ----------------------------------------------------------------------------
// MAVLink v2 frame parser assertion macros
// Concurrent assertion wrappers clocked on i_clk, gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MAVLINK_V2_FRAME_PARSER_TOP_DEFINES_SVH
`define MAVLINK_V2_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MVP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mvp assertion failed");
`define MVP_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("mvp forbidden condition seen");
`else
`define MVP_ASSERT(lbl, prop)
`define MVP_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: src/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared constants, types and CRC helpers for the MAVLink v2 frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvp_pkg;

    localparam logic [7:0]  START_BYTE   = 8'hFD;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_BAD      = 16'h0001;
    localparam logic [8:0]  HEADER_BYTES = 9'd10;
    localparam logic [8:0]  SIG_BYTES    = 9'd13;
    localparam logic [8:0]  CRC_BYTES    = 9'd2;
    localparam logic [7:0]  SIGNED_MASK  = 8'h01;

    localparam logic [8:0] POS_LEN    = 9'd1;
    localparam logic [8:0] POS_INCOMP = 9'd2;
    localparam logic [8:0] POS_SYS    = 9'd5;
    localparam logic [8:0] POS_COMP   = 9'd6;
    localparam logic [8:0] POS_ID0    = 9'd7;
    localparam logic [8:0] POS_ID1    = 9'd8;
    localparam logic [8:0] POS_ID2    = 9'd9;

    localparam int NUM_IDS = 4;

    localparam logic [1:0] REG_HEARTBEAT   = 2'd0;
    localparam logic [1:0] REG_ATTITUDE    = 2'd1;
    localparam logic [1:0] REG_GLOBAL_POS  = 2'd2;
    localparam logic [1:0] REG_COMMAND_LNG = 2'd3;

    localparam logic [23:0] RST_HEARTBEAT   = 24'd0;
    localparam logic [23:0] RST_ATTITUDE    = 24'd30;
    localparam logic [23:0] RST_GLOBAL_POS  = 24'd33;
    localparam logic [23:0] RST_COMMAND_LNG = 24'd76;

    typedef logic [NUM_IDS-1:0][23:0] t_id_set;

    typedef struct packed {
        logic [23:0] msg_id;
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [7:0]  plen;
        logic [5:0]  exp_len;
        logic        bank;
    } t_desc;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] crc_extra(input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            REG_HEARTBEAT:   v = 8'd50;
            REG_ATTITUDE:    v = 8'd39;
            REG_GLOBAL_POS:  v = 8'd104;
            REG_COMMAND_LNG: v = 8'd152;
            default:         v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] exp_len(input logic [1:0] sel);
        logic [5:0] v;
        case (sel)
            REG_HEARTBEAT:   v = 6'd9;
            REG_ATTITUDE:    v = 6'd28;
            REG_GLOBAL_POS:  v = 6'd28;
            REG_COMMAND_LNG: v = 6'd33;
            default:         v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: src/mvp_front.sv
// ----------------------------------------------------------------------------
// mvp_front
// Frame hunter and parser: tracks byte position, runs the X.25 CRC, stores
// payload bytes and queues a descriptor for every frame that passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvp_front #(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int AW            = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_rx_byte,
    input  wire mvp_pkg::t_id_set i_ids,
    output logic                  o_desc_push,
    output mvp_pkg::t_desc        o_desc,
    output logic                  o_we,
    output logic                  o_wbank,
    output logic [AW-1:0]         o_widx,
    output logic [7:0]            o_wdata
);

    localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

    logic [8:0]  r_pos,    n_pos;
    logic [7:0]  r_plen,   n_plen;
    logic        r_sig,    n_sig;
    logic [7:0]  r_sys,    n_sys;
    logic [7:0]  r_comp,   n_comp;
    logic [23:0] r_id,     n_id;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_bank,   n_bank;

    logic       w_hit;
    logic [1:0] w_sel;
    logic [8:0] w_end;
    logic [8:0] w_total;
    logic [8:0] w_pos1;
    logic [8:0] w_idx;

    always_comb begin
        w_hit = 1'b0;
        w_sel = mvp_pkg::REG_HEARTBEAT;
        for (int k = mvp_pkg::NUM_IDS - 1; k >= 0; k--) begin
            if (i_ids[k] == r_id) begin
                w_hit = 1'b1;
                w_sel = 2'(k);
            end
        end
    end

    assign w_end   = mvp_pkg::HEADER_BYTES + {1'b0, r_plen};
    assign w_total = w_end + mvp_pkg::CRC_BYTES + (r_sig ? mvp_pkg::SIG_BYTES : 9'd0);
    assign w_pos1  = r_pos + 9'd1;
    assign w_idx   = r_pos - mvp_pkg::HEADER_BYTES;

    assign o_wbank = r_bank;
    assign o_widx  = AW'(w_idx);
    assign o_wdata = i_rx_byte;

    always_comb begin
        o_desc.msg_id  = r_id;
        o_desc.sys_id  = r_sys;
        o_desc.comp_id = r_comp;
        o_desc.plen    = r_plen;
        o_desc.exp_len = mvp_pkg::exp_len(w_sel);
        o_desc.bank    = r_bank;
    end

    always_comb begin
        n_pos       = r_pos;
        n_plen      = r_plen;
        n_sig       = r_sig;
        n_sys       = r_sys;
        n_comp      = r_comp;
        n_id        = r_id;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        n_bank      = r_bank;
        o_we        = 1'b0;
        o_desc_push = 1'b0;
        if (i_valid) begin
            if (r_pos == 9'd0) begin
                if (i_rx_byte == mvp_pkg::START_BYTE) begin
                    n_pos = 9'd1;
                    n_crc = mvp_pkg::CRC_INIT;
                end
            end else begin
                if (r_pos < mvp_pkg::HEADER_BYTES) begin
                    n_crc = mvp_pkg::crc_add(r_crc, i_rx_byte);
                    case (r_pos)
                        mvp_pkg::POS_LEN:    n_plen = i_rx_byte;
                        mvp_pkg::POS_INCOMP: n_sig  = |(i_rx_byte & mvp_pkg::SIGNED_MASK);
                        mvp_pkg::POS_SYS:    n_sys  = i_rx_byte;
                        mvp_pkg::POS_COMP:   n_comp = i_rx_byte;
                        mvp_pkg::POS_ID0:    n_id   = {16'h0000, i_rx_byte};
                        mvp_pkg::POS_ID1:    n_id   = {r_id[23:16], i_rx_byte, r_id[7:0]};
                        mvp_pkg::POS_ID2:    n_id   = {i_rx_byte, r_id[15:0]};
                        default: ;
                    endcase
                end else if (r_pos < w_end) begin
                    n_crc = mvp_pkg::crc_add(r_crc, i_rx_byte);
                    o_we  = (w_idx < DEPTH9);
                end else if (r_pos == w_end) begin
                    n_crc_lo = i_rx_byte;
                end else if (r_pos == w_end + 9'd1) begin
                    if (w_hit) begin
                        n_crc = mvp_pkg::crc_add(r_crc, mvp_pkg::crc_extra(w_sel))
                                ^ {i_rx_byte, r_crc_lo};
                    end else begin
                        n_crc = mvp_pkg::CRC_BAD;
                    end
                end
                if (w_pos1 >= w_total) begin
                    n_pos = 9'd0;
                    if (w_hit && (n_crc == 16'h0000) &&
                        (r_plen <= {2'b00, mvp_pkg::exp_len(w_sel)})) begin
                        o_desc_push = 1'b1;
                        n_bank      = ~r_bank;
                    end
                end else begin
                    n_pos = w_pos1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 9'd0;
            r_plen   <= 8'd0;
            r_sig    <= 1'b0;
            r_sys    <= 8'd0;
            r_comp   <= 8'd0;
            r_id     <= 24'd0;
            r_crc    <= mvp_pkg::CRC_INIT;
            r_crc_lo <= 8'd0;
            r_bank   <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_plen   <= n_plen;
            r_sig    <= n_sig;
            r_sys    <= n_sys;
            r_comp   <= n_comp;
            r_id     <= n_id;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_bank   <= n_bank;
        end
    end

endmodule

`default_nettype wire

// File: src/mvp_desc_fifo.sv
// ----------------------------------------------------------------------------
// mvp_desc_fifo
// Two-entry queue of accepted frame descriptors between parser and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mavlink_v2_frame_parser_top_defines.svh"

module mvp_desc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mvp_pkg::t_desc i_desc,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output mvp_pkg::t_desc      o_head
);

    mvp_pkg::t_desc r_mem [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MVP_ASSERT_NEVER(a_push_when_full, i_push && !i_pop && (r_count == 2'd2))
    `MVP_ASSERT_NEVER(a_pop_when_empty, i_pop && (r_count == 2'd0))
    `MVP_ASSERT_NEVER(a_count_range, r_count == 2'd3)

endmodule

`default_nettype wire

// File: src/mvp_back.sv
// ----------------------------------------------------------------------------
// mvp_back
// Payload store and result emitter: walks each queued frame and presents its
// zero-padded payload one item at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mavlink_v2_frame_parser_top_defines.svh"

module mvp_back #(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int AW            = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_we,
    input  wire logic           i_wbank,
    input  wire logic [AW-1:0]  i_widx,
    input  wire logic [7:0]     i_wdata,
    input  wire logic           i_q_empty,
    input  wire mvp_pkg::t_desc i_head,
    output logic                o_q_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [23:0]         o_message_id,
    output logic [7:0]          o_system_id,
    output logic [7:0]          o_component_id,
    output logic [7:0]          o_payload_byte,
    output logic [5:0]          o_byte_index,
    output logic                o_last_byte
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_HOLD
    } t_state;

    logic [7:0]  r_mem [0:1][0:PAYLOAD_DEPTH-1];
    logic [7:0]  r_rdata;

    t_state      r_state;
    logic [5:0]  r_k;
    logic        r_empty;
    logic [23:0] r_msg;
    logic [7:0]  r_sys;
    logic [7:0]  r_comp;
    logic [7:0]  r_pb;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wbank][i_widx] <= i_wdata;
        end
        r_rdata <= r_mem[i_head.bank][AW'(r_k)];
    end

    assign o_q_pop        = (r_state == S_HOLD) && i_pop && r_last;
    assign o_empty        = r_empty;
    assign o_message_id   = r_msg;
    assign o_system_id    = r_sys;
    assign o_component_id = r_comp;
    assign o_payload_byte = r_pb;
    assign o_byte_index   = r_k;
    assign o_last_byte    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 6'd0;
            r_empty <= 1'b1;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_k     <= 6'd0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_msg   <= i_head.msg_id;
                    r_sys   <= i_head.sys_id;
                    r_comp  <= i_head.comp_id;
                    r_pb    <= ({2'b00, r_k} < i_head.plen) ? r_rdata : 8'h00;
                    r_last  <= ((r_k + 6'd1) == i_head.exp_len);
                    r_empty <= 1'b0;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_pop) begin
                        r_empty <= 1'b1;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 6'd1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_empty <= 1'b1;
                end
            endcase
        end
    end

    `MVP_ASSERT(a_index_in_range, !r_empty |-> (r_k < i_head.exp_len))
    `MVP_ASSERT(a_last_ends_frame, (i_pop && !r_empty && r_last) |=> r_empty)
    `MVP_ASSERT_NEVER(a_result_without_frame, !r_empty && i_q_empty)

endmodule

`default_nettype wire

// File: src/mavlink_v2_frame_parser_top.sv
// ----------------------------------------------------------------------------
// MAVLink v2 frame parser
// Byte stream in, verified and zero-padded payload bytes out.
// ----------------------------------------------------------------------------
// Input queue side: drive i_rx_byte with push; a byte is taken on a clock edge
// with push high and full low. Bytes are taken back to back while full is low;
// full rises only when two passed frames still wait for their results.
// Result queue side: while empty is low the oldest result item sits on the
// o_* ports; pop takes it. Each result item is made in order: the payload store
// is read, the output register is loaded, and the item is shown until pop takes
// it. A passed frame starts emitting once the emitter is idle and its descriptor
// is queued, and gives 9, 28 or 33 items depending on its matched id.
// Receiver stall: the shown item holds; the parser keeps taking bytes into the
// second payload bank until two frames are pending.
// Configuration: APB writes at byte address 4*i set the four message ids;
// pready is always high. Write only while the block is idle.
// Reset (synchronous, i_rst_n low): parser hunts for the start byte, queues
// empty, ids return to 0, 30, 33 and 76.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mavlink_v2_frame_parser_top #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [23:0]      o_message_id,
    output logic [7:0]       o_system_id,
    output logic [7:0]       o_component_id,
    output logic [7:0]       o_payload_byte,
    output logic [5:0]       o_byte_index,
    output logic             o_last_byte,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    mvp_pkg::t_id_set r_ids;
    logic             w_cfg_wr;
    logic             w_in_take;
    logic             w_desc_push;
    mvp_pkg::t_desc   w_desc;
    logic             w_we;
    logic             w_wbank;
    logic [AW-1:0]    w_widx;
    logic [7:0]       w_wdata;
    logic             w_q_empty;
    logic             w_q_pop;
    mvp_pkg::t_desc   w_head;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_in_take = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids[mvp_pkg::REG_HEARTBEAT]   <= mvp_pkg::RST_HEARTBEAT;
            r_ids[mvp_pkg::REG_ATTITUDE]    <= mvp_pkg::RST_ATTITUDE;
            r_ids[mvp_pkg::REG_GLOBAL_POS]  <= mvp_pkg::RST_GLOBAL_POS;
            r_ids[mvp_pkg::REG_COMMAND_LNG] <= mvp_pkg::RST_COMMAND_LNG;
        end else if (w_cfg_wr) begin
            r_ids[paddr[3:2]] <= pwdata[23:0];
        end
    end

    always_comb begin
        case (paddr[3:2])
            mvp_pkg::REG_HEARTBEAT:   prdata = {8'h00, r_ids[mvp_pkg::REG_HEARTBEAT]};
            mvp_pkg::REG_ATTITUDE:    prdata = {8'h00, r_ids[mvp_pkg::REG_ATTITUDE]};
            mvp_pkg::REG_GLOBAL_POS:  prdata = {8'h00, r_ids[mvp_pkg::REG_GLOBAL_POS]};
            mvp_pkg::REG_COMMAND_LNG: prdata = {8'h00, r_ids[mvp_pkg::REG_COMMAND_LNG]};
            default:                  prdata = 32'h0000_0000;
        endcase
    end

    mvp_front #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_take),
        .i_rx_byte   (i_rx_byte),
        .i_ids       (r_ids),
        .o_desc_push (w_desc_push),
        .o_desc      (w_desc),
        .o_we        (w_we),
        .o_wbank     (w_wbank),
        .o_widx      (w_widx),
        .o_wdata     (w_wdata)
    );

    mvp_desc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_desc_push),
        .i_desc  (w_desc),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    mvp_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (w_we),
        .i_wbank        (w_wbank),
        .i_widx         (w_widx),
        .i_wdata        (w_wdata),
        .i_q_empty      (w_q_empty),
        .i_head         (w_head),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_message_id   (o_message_id),
        .o_system_id    (o_system_id),
        .o_component_id (o_component_id),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte)
    );

endmodule

`default_nettype wire
